/* sv/fups_pkg.sv */
// ----------------------------------------------------------------------------
// fups_pkg
// Types, character codes and hex helpers for the form pair splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package fups_pkg;

    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] DELIM_RESET  = 8'h26;
    localparam int         MAX_RESULTS  = 4;
    localparam int         HEX_RADIX    = 16;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_MARK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_BETWEEN = 2'd0,
        PH_KEY     = 2'd1,
        PH_VALUE   = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_PERCENT = 2'd1,
        PEND_DIGIT   = 2'd2
    } pend_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_body;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        begin
            r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
            return r;
        end
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c inside {[8'h30:8'h39]})
            begin
                d = c - 8'h30;
            end
            else if (c inside {[8'h61:8'h66]})
            begin
                d = c - 8'h61 + 8'(HEX_RADIX - 6);
            end
            else
            begin
                d = c - 8'h41 + 8'(HEX_RADIX - 6);
            end
            return d[3:0];
        end
    endfunction

    function automatic out_item_t mk_result(input kind_t k, input logic [7:0] b);
        out_item_t r;
        begin
            r.kind        = k;
            r.out_byte    = b;
            r.last_of_run = 1'b0;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/form_urlencoded_pair_splitter.sv */
// ----------------------------------------------------------------------------
// form_urlencoded_pair_splitter
// Splits a form-encoded body into decoded key and value bytes with markers.
// ----------------------------------------------------------------------------
// An accepted item is registered, then its results are loaded into the result buffer.
// Throughput: one item per cycle while items give at most one result and
//   result_ready holds; n results (n at most 4) hold the buffer until taken.
// Reset: asynchronous, active low; returns to between pairs, delimiter '&'.
// ----------------------------------------------------------------------------
`default_nettype none

module form_urlencoded_pair_splitter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire fups_pkg::in_item_t  item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output fups_pkg::out_item_t      result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);
    import fups_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W = $clog2(MAX_RESULTS);

    in_item_t        item_reg;
    logic            item_valid_reg;
    logic            item_valid_next;
    logic [7:0]      delim_reg;
    phase_t          phase_reg;
    phase_t          phase_next;
    pend_t           pend_reg;
    pend_t           pend_next;
    logic [7:0]      digit_reg;
    logic [7:0]      digit_next;
    logic            cut_reg;
    logic            cut_next;
    logic            ended_reg;
    logic            ended_next;
    out_item_t       res_reg [MAX_RESULTS];
    out_item_t       res_next [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    out_item_t       calc [MAX_RESULTS];
    logic [CNT_W-1:0] n;
    logic [7:0]      b;
    logic [7:0]      v;
    kind_t           k;
    logic            load;
    logic            pop;
    logic            do_close;
    logic            do_decode;
    logic            do_split;
    logic            done;

    assign cfg_ready    = 1'b1;
    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && result_ready;
    assign load         = item_valid_reg
                          && ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && result_ready));
    assign item_ready   = !item_valid_reg || load;

    always_comb
    begin
        result             = res_reg[0];
        result.last_of_run = (cnt_reg == CNT_W'(1));
    end

    // decode one item against the current pair state
    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        cut_next   = cut_reg;
        ended_next = ended_reg;
        n          = '0;
        b          = item_reg.in_byte;
        v          = {hex_val(digit_reg), hex_val(b)};
        do_close   = 1'b0;
        do_decode  = 1'b0;
        do_split   = 1'b0;
        done       = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            calc[i] = mk_result(KIND_MARK, CH_NUL);
        end

        if (!ended_reg)
        begin
            if (b == CH_NUL)
            begin
                do_close   = 1'b1;
                ended_next = 1'b1;
            end
            else if (b == delim_reg)
            begin
                do_close = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_BETWEEN:
                    begin
                        if (b == CH_EQUAL)
                        begin
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            phase_next = PH_KEY;
                            do_decode  = 1'b1;
                        end
                    end
                    PH_KEY:
                    begin
                        if (b == CH_EQUAL)
                        begin
                            do_split = 1'b1;
                        end
                        else
                        begin
                            do_decode = 1'b1;
                        end
                    end
                    PH_VALUE:
                    begin
                        do_decode = 1'b1;
                    end
                    default:
                    begin
                        do_decode = 1'b0;
                    end
                endcase
            end
        end

        k = (phase_next == PH_VALUE) ? KIND_VALUE : KIND_KEY;

        if (do_decode && !cut_reg)
        begin
            if (pend_reg == PEND_DIGIT)
            begin
                if (is_hex(b))
                begin
                    pend_next = PEND_NONE;
                    done      = 1'b1;
                    if (v == CH_NUL)
                    begin
                        cut_next = 1'b1;
                    end
                    else
                    begin
                        calc[n[IDX_W-1:0]] = mk_result(k, v);
                        n = n + CNT_W'(1);
                    end
                end
                else
                begin
                    calc[n[IDX_W-1:0]] = mk_result(k, CH_PERCENT);
                    n = n + CNT_W'(1);
                    calc[n[IDX_W-1:0]] = mk_result(k, digit_reg);
                    n = n + CNT_W'(1);
                    pend_next = PEND_NONE;
                end
            end
            else if (pend_reg == PEND_PERCENT)
            begin
                if (is_hex(b))
                begin
                    digit_next = b;
                    pend_next  = PEND_DIGIT;
                    done       = 1'b1;
                end
                else
                begin
                    calc[n[IDX_W-1:0]] = mk_result(k, CH_PERCENT);
                    n = n + CNT_W'(1);
                    pend_next = PEND_NONE;
                end
            end
            if (!done)
            begin
                if (b == CH_PERCENT)
                begin
                    pend_next = PEND_PERCENT;
                end
                else if (b == CH_PLUS)
                begin
                    calc[n[IDX_W-1:0]] = mk_result(k, CH_SPACE);
                    n = n + CNT_W'(1);
                end
                else
                begin
                    calc[n[IDX_W-1:0]] = mk_result(k, b);
                    n = n + CNT_W'(1);
                end
            end
        end

        // '=' in the key: flush the key field and move to the value
        if (do_split)
        begin
            if (!cut_reg && (pend_reg != PEND_NONE))
            begin
                calc[n[IDX_W-1:0]] = mk_result(KIND_KEY, CH_PERCENT);
                n = n + CNT_W'(1);
                if (pend_reg == PEND_DIGIT)
                begin
                    calc[n[IDX_W-1:0]] = mk_result(KIND_KEY, digit_reg);
                    n = n + CNT_W'(1);
                end
            end
            pend_next  = PEND_NONE;
            digit_next = CH_NUL;
            cut_next   = 1'b0;
            phase_next = PH_VALUE;
        end

        // close the open pair on delimiter, raw zero or end of body
        if (do_close || item_reg.end_of_body)
        begin
            if ((phase_next == PH_KEY) || (phase_next == PH_VALUE))
            begin
                k = (phase_next == PH_VALUE) ? KIND_VALUE : KIND_KEY;
                if (!cut_next && (pend_next != PEND_NONE))
                begin
                    calc[n[IDX_W-1:0]] = mk_result(k, CH_PERCENT);
                    n = n + CNT_W'(1);
                    if (pend_next == PEND_DIGIT)
                    begin
                        calc[n[IDX_W-1:0]] = mk_result(k, digit_next);
                        n = n + CNT_W'(1);
                    end
                end
                calc[n[IDX_W-1:0]] = mk_result(KIND_MARK, CH_NUL);
                n = n + CNT_W'(1);
            end
            phase_next = PH_BETWEEN;
            pend_next  = PEND_NONE;
            digit_next = CH_NUL;
            cut_next   = 1'b0;
        end

        if (item_reg.end_of_body)
        begin
            ended_next = 1'b0;
        end
    end

    // result buffer: load a whole run, or advance one entry per transfer
    always_comb
    begin
        item_valid_next = item_valid_reg;
        cnt_next        = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (item_ready)
        begin
            item_valid_next = item_valid;
        end
        if (load)
        begin
            cnt_next = n;
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_next[i] = calc[i];
            end
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            delim_reg      <= DELIM_RESET;
            phase_reg      <= PH_BETWEEN;
            pend_reg       <= PEND_NONE;
            digit_reg      <= CH_NUL;
            cut_reg        <= 1'b0;
            ended_reg      <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                delim_reg <= cfg_data;
            end
            if (load)
            begin
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                digit_reg <= digit_next;
                cut_reg   <= cut_next;
                ended_reg <= ended_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

endmodule

`default_nettype wire

/* verif/form_urlencoded_pair_splitter_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// form_urlencoded_pair_splitter_check
// Watches the item, result and delimiter channels of the pair splitter. On
// each item transfer it decodes the byte with its own copy of the splitter
// state and queues the key, value and marker outputs it expects. Each result
// transfer is compared field by field against the oldest queued output.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_splitter_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  fups_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  fups_pkg::out_item_t result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output int                  fail_count,
    output int                  awaiting
);
    import fups_pkg::*;

    logic [7:0] delim;
    phase_t     cur_phase;
    pend_t      esc_state;
    logic [7:0] esc_digit;
    logic       cut;
    logic       body_done;
    int         errs;
    out_item_t  run_q[$];
    out_item_t  decoded_q[$];

    function automatic logic hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] n;
        if (c <= "9")
        begin
            n = c - "0";
        end
        else if (c >= "a")
        begin
            n = c - "a" + 8'd10;
        end
        else
        begin
            n = c - "A" + 8'd10;
        end
        return n[3:0];
    endfunction

    function automatic kind_t field_kind();
        return (cur_phase == PH_VALUE) ? KIND_VALUE : KIND_KEY;
    endfunction

    function automatic void put_byte(input kind_t k, input logic [7:0] b);
        out_item_t r;
        r.kind        = k;
        r.out_byte    = b;
        r.last_of_run = 1'b0;
        if (run_q.size() < MAX_RESULTS)
        begin
            run_q.push_back(r);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        kind_t      k;
        logic [7:0] v;
        k = field_kind();
        if (cut)
        begin
            return;
        end
        if (esc_state == PEND_DIGIT)
        begin
            if (hex_char(b))
            begin
                v = {nibble_of(esc_digit), nibble_of(b)};
                esc_state = PEND_NONE;
                if (v == 8'h00)
                begin
                    cut = 1'b1;
                end
                else
                begin
                    put_byte(k, v);
                end
                return;
            end
            put_byte(k, CH_PERCENT);
            put_byte(k, esc_digit);
            esc_state = PEND_NONE;
        end
        else if (esc_state == PEND_PERCENT)
        begin
            if (hex_char(b))
            begin
                esc_digit = b;
                esc_state = PEND_DIGIT;
                return;
            end
            put_byte(k, CH_PERCENT);
            esc_state = PEND_NONE;
        end
        if (b == CH_PERCENT)
        begin
            esc_state = PEND_PERCENT;
        end
        else if (b == CH_PLUS)
        begin
            put_byte(k, CH_SPACE);
        end
        else
        begin
            put_byte(k, b);
        end
    endfunction

    function automatic void end_field();
        kind_t k;
        k = field_kind();
        if (!cut)
        begin
            if (esc_state != PEND_NONE)
            begin
                put_byte(k, CH_PERCENT);
            end
            if (esc_state == PEND_DIGIT)
            begin
                put_byte(k, esc_digit);
            end
        end
        esc_state = PEND_NONE;
        esc_digit = 8'h00;
        cut       = 1'b0;
    endfunction

    function automatic void close_pair();
        if (cur_phase == PH_KEY || cur_phase == PH_VALUE)
        begin
            end_field();
            put_byte(KIND_MARK, 8'h00);
        end
        cur_phase = PH_BETWEEN;
        esc_state = PEND_NONE;
        esc_digit = 8'h00;
        cut       = 1'b0;
    endfunction

    function automatic void decode_item(input in_item_t it);
        logic [7:0] b;
        b = it.in_byte;
        run_q.delete();
        if (!body_done)
        begin
            if (b == CH_NUL)
            begin
                close_pair();
                body_done = 1'b1;
            end
            else if (b == delim)
            begin
                close_pair();
            end
            else if (cur_phase == PH_BETWEEN)
            begin
                if (b == CH_EQUAL)
                begin
                    cur_phase = PH_DROP;
                end
                else
                begin
                    cur_phase = PH_KEY;
                    decode_byte(b);
                end
            end
            else if (cur_phase == PH_KEY)
            begin
                if (b == CH_EQUAL)
                begin
                    end_field();
                    cur_phase = PH_VALUE;
                end
                else
                begin
                    decode_byte(b);
                end
            end
            else if (cur_phase == PH_VALUE)
            begin
                decode_byte(b);
            end
        end
        if (it.end_of_body)
        begin
            close_pair();
            body_done = 1'b0;
        end
        if (run_q.size() > 0)
        begin
            run_q[run_q.size() - 1].last_of_run = 1'b1;
        end
        foreach (run_q[i])
        begin
            decoded_q.push_back(run_q[i]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            delim      = DELIM_RESET;
            cur_phase  = PH_BETWEEN;
            esc_state  = PEND_NONE;
            esc_digit  = 8'h00;
            cut        = 1'b0;
            body_done  = 1'b0;
            errs       = 0;
            decoded_q.delete();
            fail_count <= 0;
            awaiting   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %h last %b",
                             $time, result.kind, result.out_byte, result.last_of_run);
                    errs++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (result.kind !== want.kind)
                    begin
                        $display("%0t: kind mismatch, expected %0d, actual %0d",
                                 $time, want.kind, result.kind);
                        errs++;
                    end
                    if (result.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch, expected %h, actual %h",
                                 $time, want.out_byte, result.out_byte);
                        errs++;
                    end
                    if (result.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run mismatch, expected %b, actual %b",
                                 $time, want.last_of_run, result.last_of_run);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                delim = cfg_data;
            end
            if (item_valid && item_ready)
            begin
                decode_item(item);
            end
            fail_count <= errs;
            awaiting   <= decoded_q.size();
        end
    end

endmodule

/* verif/form_urlencoded_pair_splitter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// form_urlencoded_pair_splitter_test
// Drives form-encoded bodies into the pair splitter: a directed run over
// escapes, empty and dropped pairs, decoded and raw zeros, then random bodies
// under several delimiters and sender/receiver idle profiles. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module form_urlencoded_pair_splitter_test;
    import fups_pkg::*;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    in_item_t   item         = '0;
    logic       result_ready = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic [7:0] cfg_data     = 8'h00;
    logic       item_ready;
    logic       result_valid;
    out_item_t  result;
    logic       cfg_ready;
    int         fail_count;
    int         awaiting;

    int         send_idle = 0;
    int         stall_pct = 0;
    in_item_t   raw_q[$];

    int         idle_of[4]  = '{0, 69, 0, 19};
    int         stall_of[4] = '{0, 0, 69, 19};
    logic [7:0] delim_of[7] = '{8'h3B, 8'hFF, CH_NUL, CH_EQUAL, CH_PERCENT, CH_PLUS,
                                DELIM_RESET};

    form_urlencoded_pair_splitter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    form_urlencoded_pair_splitter_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .awaiting     (awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void add_raw(input logic [7:0] b, input logic eob);
        in_item_t it;
        it.in_byte     = b;
        it.end_of_body = eob;
        raw_q.push_back(it);
    endfunction

    function automatic logic [7:0] hex_pick();
        int r;
        r = $urandom_range(21);
        if (r < 10)
        begin
            return 8'("0" + r);
        end
        else if (r < 16)
        begin
            return 8'("a" + r - 10);
        end
        return 8'("A" + r - 16);
    endfunction

    function automatic void add_token();
        int r;
        r = $urandom_range(19);
        if (r < 10)
        begin
            add_raw(8'("a" + $urandom_range(25)), 1'b0);
        end
        else if (r < 12)
        begin
            add_raw(CH_PLUS, 1'b0);
        end
        else if (r < 15)
        begin
            add_raw(CH_PERCENT, 1'b0);
            add_raw(hex_pick(), 1'b0);
            add_raw(hex_pick(), 1'b0);
        end
        else if (r == 15)
        begin
            add_raw(CH_PERCENT, 1'b0);
            add_raw(8'("g" + $urandom_range(19)), 1'b0);
        end
        else if (r == 16)
        begin
            add_raw(CH_PERCENT, 1'b0);
            add_raw(hex_pick(), 1'b0);
        end
        else if (r == 17)
        begin
            add_raw(CH_PERCENT, 1'b0);
            add_raw("0", 1'b0);
            add_raw("0", 1'b0);
        end
        else
        begin
            add_raw(8'($urandom_range(1, 255)), 1'b0);
        end
    endfunction

    function automatic void make_body(input logic [7:0] d);
        int npairs;
        int n;
        if ($urandom_range(7) == 0)
        begin
            n = $urandom_range(1, 5);
            repeat (n) add_raw(8'($urandom_range(255)), ($urandom_range(5) == 0));
            raw_q[raw_q.size() - 1].end_of_body = 1'b1;
            return;
        end
        npairs = $urandom_range(1, 4);
        for (int i = 0; i < npairs; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                add_raw(d, 1'b0);
            end
            if ($urandom_range(9) == 0)
            begin
                add_raw(CH_EQUAL, 1'b0);
            end
            repeat ($urandom_range(1, 3)) add_token();
            if ($urandom_range(3) != 0)
            begin
                add_raw(CH_EQUAL, 1'b0);
                repeat ($urandom_range(0, 3)) add_token();
            end
            if (i < npairs - 1)
            begin
                add_raw(d, 1'b0);
            end
        end
        if ($urandom_range(9) == 0)
        begin
            add_raw(CH_NUL, 1'b0);
            add_token();
        end
        raw_q[raw_q.size() - 1].end_of_body = 1'b1;
    endfunction

    task automatic push_item(input in_item_t it);
        int gap;
        gap = 0;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        while ($urandom_range(99) < send_idle) gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_all();
        foreach (raw_q[i])
        begin
            push_item(raw_q[i]);
        end
        raw_q.delete();
    endtask

    // hold until every expected result has come, then let the pipeline drain
    task automatic settle();
        item_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (awaiting != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_delim(input logic [7:0] d);
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        bit held;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        add_raw("k", 1'b0);
        add_raw(CH_PLUS, 1'b0);
        add_raw(CH_EQUAL, 1'b0);
        add_raw(CH_PERCENT, 1'b0);
        add_raw("4", 1'b0);
        add_raw("1", 1'b0);
        add_raw(CH_PERCENT, 1'b0);
        add_raw("z", 1'b0);
        add_raw(DELIM_RESET, 1'b0);
        add_raw(DELIM_RESET, 1'b0);
        add_raw(CH_EQUAL, 1'b0);
        add_raw("x", 1'b0);
        add_raw(DELIM_RESET, 1'b0);
        add_raw(CH_PERCENT, 1'b0);
        add_raw("0", 1'b0);
        add_raw("0", 1'b0);
        add_raw("q", 1'b0);
        add_raw(CH_EQUAL, 1'b0);
        add_raw(8'hFF, 1'b0);
        add_raw(CH_PERCENT, 1'b0);
        add_raw("f", 1'b0);
        add_raw(CH_PERCENT, 1'b1);
        add_raw("a", 1'b0);
        add_raw(CH_NUL, 1'b0);
        add_raw("b", 1'b0);
        add_raw("c", 1'b1);
        push_all();
        settle();

        for (int p = 0; p < 7; p++)
        begin
            write_delim(delim_of[p]);
            send_idle = idle_of[p % 4];
            stall_pct = stall_of[p % 4];
            sent = 0;
            held = 1'b0;
            while (sent < 8)
            begin
                make_body(delim_of[p]);
                sent += raw_q.size();
                push_all();
                if (!held && sent >= 4)
                begin
                    settle();
                    held = 1'b1;
                end
            end
            settle();
        end

        if (fail_count == 0 && awaiting == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/fups_pkg.sv
sv/form_urlencoded_pair_splitter.sv
verif/form_urlencoded_pair_splitter_check.sv
verif/form_urlencoded_pair_splitter_test.sv
